// ----- rtl/core/baro_average_and_compensate_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the barometer averaging and compensation block
// ----------------------------------------------------------------------------
`ifndef BARO_AVERAGE_AND_COMPENSATE_TOP_MACROS_SVH
`define BARO_AVERAGE_AND_COMPENSATE_TOP_MACROS_SVH

// same-cycle implication, clocked on clock, off during reset
`define BARO_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BARO_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/baro_pkg.sv -----
// ----------------------------------------------------------------------------
// baro_pkg
// Shared types and constants of the barometer averaging and compensation block.
// ----------------------------------------------------------------------------
`default_nettype none

package baro_pkg;

   localparam int SAMPLE_W   = 24;
   localparam int COEFF_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int PRESS_W    = 23;
   localparam int TEMP_W     = 19;

   // calibration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SENS        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SENS_TEMP   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_TEMP = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_TEMP    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_SLOPE  = 3'd5;

   // 20.00 degC base of the temperature formula
   localparam logic signed [19:0] TEMP_BASE = 20'sd2000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_DT,
      ST_MUL_T,
      ST_MUL_O,
      ST_MUL_S,
      ST_SENS,
      ST_MUL_L,
      ST_MUL_H,
      ST_FULL,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      MUL_DT_C6,
      MUL_DT_C4,
      MUL_DT_C3,
      MUL_D1_LO,
      MUL_D1_HI
   } mul_sel_type;

   typedef struct packed {
      logic        ring_wr;
      logic        div_start;
      logic        ld_dt;
      logic        ld_temp;
      logic        ld_off;
      logic        ld_sens;
      logic        ld_lo;
      logic        ld_full;
      logic        ld_rsp;
      mul_sel_type mul_sel;
   } ctrl_type;

endpackage

`default_nettype wire

// ----- rtl/core/baro_average_and_compensate_top.sv -----
// ----------------------------------------------------------------------------
// baro_average_and_compensate_top
// Averages raw pressure and temperature conversions over rings of recent
// samples and applies first-order barometer compensation.
// ----------------------------------------------------------------------------
//  channel | dir | signals                                   | handshake
//  req     | in  | req_cmd, req_sample                       | req_valid/req_ready
//  rsp     | out | rsp_pressure, rsp_temperature, rsp_avg_*  | rsp_valid/rsp_ready
//  csr     | in  | csr_index, csr_data                       | csr_valid/csr_ready
//
//  A temperature item is a ring read, then a write and running-sum update.
//  A pressure item adds to these the reciprocal mean multipliers, dT and the
//  shared 25x18 multiplier that runs the compensation in five passes, and the
//  output load. One item is in work at a time.
//  Ring valid bits clear at reset; entries never written read as zero.
//  A finished result waits in the output register while the next item is taken;
//  each cycle a previous result stays stalled holds the next one in ST_OUT.
// ----------------------------------------------------------------------------
`default_nettype none

module baro_average_and_compensate_top #(
   parameter int PRESSURE_SAMPLES    = 8,
   parameter int TEMPERATURE_SAMPLES = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic        req_cmd,
   input  wire logic [23:0] req_sample,

   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      logic signed [22:0] rsp_pressure,
   output      logic signed [18:0] rsp_temperature,
   output      logic [23:0]        rsp_avg_pressure_raw,
   output      logic [23:0]        rsp_avg_temperature_raw,

   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   localparam int SW       = baro_pkg::SAMPLE_W;
   localparam int P_SLOT_W = (PRESSURE_SAMPLES > 1) ? $clog2(PRESSURE_SAMPLES) : 1;
   localparam int T_SLOT_W = (TEMPERATURE_SAMPLES > 1) ? $clog2(TEMPERATURE_SAMPLES) : 1;
   localparam int P_SUM_W  = SW + $clog2(PRESSURE_SAMPLES);
   localparam int T_SUM_W  = SW + $clog2(TEMPERATURE_SAMPLES);
   localparam logic [P_SLOT_W-1:0] P_LAST = P_SLOT_W'(PRESSURE_SAMPLES - 1);
   localparam logic [T_SLOT_W-1:0] T_LAST = T_SLOT_W'(TEMPERATURE_SAMPLES - 1);

   // ---------------- calibration registers ----------------
   logic [15:0] c1_ff, c2_ff, c3_ff, c4_ff, c5_ff, c6_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= '0;
         c2_ff <= '0;
         c3_ff <= '0;
         c4_ff <= '0;
         c5_ff <= '0;
         c6_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            baro_pkg::CSR_SENS:        c1_ff <= csr_data;
            baro_pkg::CSR_OFFSET:      c2_ff <= csr_data;
            baro_pkg::CSR_SENS_TEMP:   c3_ff <= csr_data;
            baro_pkg::CSR_OFFSET_TEMP: c4_ff <= csr_data;
            baro_pkg::CSR_REF_TEMP:    c5_ff <= csr_data;
            baro_pkg::CSR_TEMP_SLOPE:  c6_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------- sequencer ----------------
   baro_pkg::state_type state_ff, state_in;
   baro_pkg::ctrl_type  ctrl;
   logic                req_accept;
   logic                out_free;
   logic                p_busy, t_busy;
   logic                cmd_ff;
   logic                rsp_valid_ff, rsp_valid_in;

   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         baro_pkg::ST_IDLE:     if (req_valid) state_in = baro_pkg::ST_UPDATE;
         baro_pkg::ST_UPDATE:   state_in = cmd_ff ? baro_pkg::ST_IDLE : baro_pkg::ST_DIV_GO;
         baro_pkg::ST_DIV_GO:   state_in = baro_pkg::ST_DIV_WAIT;
         baro_pkg::ST_DIV_WAIT: if (!p_busy && !t_busy) state_in = baro_pkg::ST_DT;
         baro_pkg::ST_DT:       state_in = baro_pkg::ST_MUL_T;
         baro_pkg::ST_MUL_T:    state_in = baro_pkg::ST_MUL_O;
         baro_pkg::ST_MUL_O:    state_in = baro_pkg::ST_MUL_S;
         baro_pkg::ST_MUL_S:    state_in = baro_pkg::ST_SENS;
         baro_pkg::ST_SENS:     state_in = baro_pkg::ST_MUL_L;
         baro_pkg::ST_MUL_L:    state_in = baro_pkg::ST_MUL_H;
         baro_pkg::ST_MUL_H:    state_in = baro_pkg::ST_FULL;
         baro_pkg::ST_FULL:     state_in = baro_pkg::ST_OUT;
         baro_pkg::ST_OUT:      if (out_free) state_in = baro_pkg::ST_IDLE;
         default:               state_in = baro_pkg::ST_IDLE;
      endcase
   end

   // the product register holds what the previous state selected
   always_comb begin
      ctrl         = '0;
      ctrl.mul_sel = baro_pkg::MUL_DT_C6;
      unique case (state_ff)
         baro_pkg::ST_UPDATE:   ctrl.ring_wr = 1'b1;
         baro_pkg::ST_DIV_GO:   ctrl.div_start = 1'b1;
         baro_pkg::ST_DT:       ctrl.ld_dt = 1'b1;
         baro_pkg::ST_MUL_T:    ctrl.mul_sel = baro_pkg::MUL_DT_C6;
         baro_pkg::ST_MUL_O: begin
            ctrl.mul_sel = baro_pkg::MUL_DT_C4;
            ctrl.ld_temp = 1'b1;
         end
         baro_pkg::ST_MUL_S: begin
            ctrl.mul_sel = baro_pkg::MUL_DT_C3;
            ctrl.ld_off  = 1'b1;
         end
         baro_pkg::ST_SENS:     ctrl.ld_sens = 1'b1;
         baro_pkg::ST_MUL_L:    ctrl.mul_sel = baro_pkg::MUL_D1_LO;
         baro_pkg::ST_MUL_H: begin
            ctrl.mul_sel = baro_pkg::MUL_D1_HI;
            ctrl.ld_lo   = 1'b1;
         end
         baro_pkg::ST_FULL:     ctrl.ld_full = 1'b1;
         baro_pkg::ST_OUT:      ctrl.ld_rsp = out_free;
         default: ;
      endcase
   end

   assign req_ready = (state_ff == baro_pkg::ST_IDLE);

   // ---------------- rings and running sums ----------------
   logic [SW-1:0]         sample_ff;
   logic [P_SLOT_W-1:0]   p_slot_ff, p_slot_in;
   logic [T_SLOT_W-1:0]   t_slot_ff, t_slot_in;
   logic [PRESSURE_SAMPLES-1:0]    p_valid_ff, p_valid_in;
   logic [TEMPERATURE_SAMPLES-1:0] t_valid_ff, t_valid_in;
   logic [P_SUM_W-1:0]    p_sum_ff, p_sum_in;
   logic [T_SUM_W-1:0]    t_sum_ff, t_sum_in;
   logic [SW-1:0]         p_rd_data, t_rd_data, p_old, t_old;
   logic                  p_wr, t_wr;

   assign p_wr = ctrl.ring_wr && !cmd_ff;
   assign t_wr = ctrl.ring_wr && cmd_ff;

   baro_ram #(.WIDTH(SW), .DEPTH(PRESSURE_SAMPLES)) u_p_ring (
      .clock   (clock),
      .wr_en   (p_wr),
      .wr_addr (p_slot_ff),
      .wr_data (sample_ff),
      .rd_en   (req_accept && !req_cmd),
      .rd_addr (p_slot_ff),
      .rd_data (p_rd_data)
   );

   baro_ram #(.WIDTH(SW), .DEPTH(TEMPERATURE_SAMPLES)) u_t_ring (
      .clock   (clock),
      .wr_en   (t_wr),
      .wr_addr (t_slot_ff),
      .wr_data (sample_ff),
      .rd_en   (req_accept && req_cmd),
      .rd_addr (t_slot_ff),
      .rd_data (t_rd_data)
   );

   always_comb begin
      p_old      = p_valid_ff[p_slot_ff] ? p_rd_data : '0;
      t_old      = t_valid_ff[t_slot_ff] ? t_rd_data : '0;
      p_sum_in   = p_sum_ff;
      t_sum_in   = t_sum_ff;
      p_slot_in  = p_slot_ff;
      t_slot_in  = t_slot_ff;
      p_valid_in = p_valid_ff;
      t_valid_in = t_valid_ff;
      // replace the oldest entry: sum loses it and gains the new sample
      if (p_wr) begin
         p_sum_in              = p_sum_ff - P_SUM_W'(p_old) + P_SUM_W'(sample_ff);
         p_valid_in[p_slot_ff] = 1'b1;
         p_slot_in             = (p_slot_ff == P_LAST) ? '0 : p_slot_ff + 1'b1;
      end
      if (t_wr) begin
         t_sum_in              = t_sum_ff - T_SUM_W'(t_old) + T_SUM_W'(sample_ff);
         t_valid_in[t_slot_ff] = 1'b1;
         t_slot_in             = (t_slot_ff == T_LAST) ? '0 : t_slot_ff + 1'b1;
      end
   end

   // ---------------- means ----------------
   logic [SW-1:0] d1, d2;

   baro_div #(.DIVISOR(PRESSURE_SAMPLES), .DVD_W(P_SUM_W), .QUO_W(SW)) u_p_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.div_start),
      .dividend (p_sum_ff),
      .busy     (p_busy),
      .quotient (d1)
   );

   baro_div #(.DIVISOR(TEMPERATURE_SAMPLES), .DVD_W(T_SUM_W), .QUO_W(SW)) u_t_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.div_start),
      .dividend (t_sum_ff),
      .busy     (t_busy),
      .quotient (d2)
   );

   // ---------------- compensation datapath ----------------
   logic signed [24:0] dt_ff, dt_in;
   logic signed [24:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [42:0] prod_ff, prod_in;
   logic signed [18:0] temp_ff, temp_in;
   logic signed [36:0] off_ff, off_in;
   logic signed [33:0] sens_ff, sens_in;
   logic [40:0]        lo_ff, lo_in;
   logic [57:0]        full_ff, full_in;
   logic signed [19:0] temp_sum;
   logic signed [35:0] sens_sum;
   logic signed [36:0] p_diff;

   always_comb begin
      case (ctrl.mul_sel)
         baro_pkg::MUL_DT_C4: begin
            mul_a = dt_ff;
            mul_b = {2'b00, c4_ff};
         end
         baro_pkg::MUL_DT_C3: begin
            mul_a = dt_ff;
            mul_b = {2'b00, c3_ff};
         end
         baro_pkg::MUL_D1_LO: begin
            mul_a = {1'b0, d1};
            mul_b = {1'b0, sens_ff[16:0]};
         end
         baro_pkg::MUL_D1_HI: begin
            mul_a = {1'b0, d1};
            mul_b = {sens_ff[33], sens_ff[33:17]};
         end
         default: begin
            mul_a = dt_ff;
            mul_b = {2'b00, c6_ff};
         end
      endcase
      prod_in = mul_a * mul_b;

      dt_in    = ctrl.ld_dt ? ($signed({1'b0, d2}) - $signed({1'b0, c5_ff, 8'd0})) : dt_ff;

      temp_sum = $signed(prod_ff[42:23]) + baro_pkg::TEMP_BASE;
      temp_in  = ctrl.ld_temp ? temp_sum[18:0] : temp_ff;

      off_in   = ctrl.ld_off ?
                 ($signed({5'd0, c2_ff, 16'd0}) + $signed({prod_ff[42], prod_ff[42:7]})) :
                 off_ff;

      sens_sum = $signed({5'd0, c1_ff, 15'd0}) + $signed({prod_ff[42], prod_ff[42:8]});
      sens_in  = ctrl.ld_sens ? sens_sum[33:0] : sens_ff;

      lo_in    = ctrl.ld_lo ? prod_ff[40:0] : lo_ff;
      // high partial product weighs 2^17
      full_in  = ctrl.ld_full ? ({prod_ff[40:0], 17'd0} + {17'd0, lo_ff}) : full_ff;

      p_diff   = $signed(full_ff[57:21]) - off_ff;
   end

   // ---------------- result register ----------------
   always_comb begin
      rsp_valid_in = ctrl.ld_rsp || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= baro_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         p_slot_ff    <= '0;
         t_slot_ff    <= '0;
         p_valid_ff   <= '0;
         t_valid_ff   <= '0;
         p_sum_ff     <= '0;
         t_sum_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         p_slot_ff    <= p_slot_in;
         t_slot_ff    <= t_slot_in;
         p_valid_ff   <= p_valid_in;
         t_valid_ff   <= t_valid_in;
         p_sum_ff     <= p_sum_in;
         t_sum_ff     <= t_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff    <= req_cmd;
         sample_ff <= req_sample;
      end
      prod_ff <= prod_in;
      dt_ff   <= dt_in;
      temp_ff <= temp_in;
      off_ff  <= off_in;
      sens_ff <= sens_in;
      lo_ff   <= lo_in;
      full_ff <= full_in;
      if (ctrl.ld_rsp) begin
         rsp_pressure            <= {p_diff[36], p_diff[36:15]};
         rsp_temperature         <= temp_ff;
         rsp_avg_pressure_raw    <= d1;
         rsp_avg_temperature_raw <= d2;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- rtl/core/baro_ram.sv -----
// ----------------------------------------------------------------------------
// baro_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module baro_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 8
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/baro_div.sv -----
// ----------------------------------------------------------------------------
// baro_div
// Division by a fixed divisor through multiplication by a rounded-up
// reciprocal; the dividend is registered at start, then the product.
// ----------------------------------------------------------------------------
`default_nettype none

module baro_div #(
   parameter int DIVISOR = 8,
   parameter int DVD_W   = 27,
   parameter int QUO_W   = 24
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   output      logic             busy,
   output      logic [QUO_W-1:0] quotient
);

   localparam int SHIFT   = DVD_W + $clog2(DIVISOR);
   localparam int RECIP_W = DVD_W + 1;
   localparam int PROD_W  = DVD_W + RECIP_W;
   // ceil(2^SHIFT / DIVISOR) gives the exact floor quotient for any DVD_W-bit dividend
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

   logic [DVD_W-1:0]  dvd_ff;
   logic [PROD_W-1:0] prod_ff;
   logic              busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= start;
      end
      if (start) begin
         dvd_ff <= dividend;
      end
      if (busy_ff) begin
         prod_ff <= dvd_ff * RECIP;
      end
   end

   assign busy     = busy_ff;
   assign quotient = prod_ff[SHIFT +: QUO_W];

endmodule

`default_nettype wire

// ----- rtl/core/baro_checker.sv -----
// ----------------------------------------------------------------------------
// baro_checker
// Port-level checks of the barometer averaging and compensation block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "baro_average_and_compensate_top_macros.svh"

module baro_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               req_cmd,
   input wire logic [23:0]        req_sample,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic signed [22:0] rsp_pressure,
   input wire logic signed [18:0] rsp_temperature,
   input wire logic [23:0]        rsp_avg_pressure_raw,
   input wire logic [23:0]        rsp_avg_temperature_raw,
   input wire logic               csr_valid,
   input wire logic               csr_ready,
   input wire logic [2:0]         csr_index,
   input wire logic [15:0]        csr_data
);

   // a stalled item stays put
   `BARO_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pressure) && $stable(rsp_temperature) && $stable(rsp_avg_pressure_raw) && $stable(rsp_avg_temperature_raw), "rsp item changed while stalled")

   // one item in work at a time
   `BARO_ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready, "req taken while an item is in work")

   // a new result only comes out of a busy sequencer
   `BARO_ASSERT_NOW(a_rsp_source, $rose(rsp_valid), $past(!req_ready), "result appeared from an idle block")

   // dT*C6/2^23 stays within 17 bits, so temperature sits around 20.00 degC
   `BARO_ASSERT_NOW(a_temp_range, rsp_valid, rsp_temperature <= 19'sd133071 && rsp_temperature >= -19'sd129072, "temperature outside reachable range")

endmodule

bind baro_average_and_compensate_top baro_checker u_baro_checker (.*);

`default_nettype wire

// ----- tb/sv/baro_average_and_compensate_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// baro_average_and_compensate_top_tb
// Sends tagged pressure and temperature conversions through the block under
// several calibration settings. A scoreboard keeps its own copy of both sample
// rings and the coefficients, computes the averaged and compensated result of
// each pressure item, and compares it field by field with the block's output.
// ----------------------------------------------------------------------------

module baro_average_and_compensate_top_tb;

   localparam int SAMPLE_W  = baro_pkg::SAMPLE_W;
   localparam int COEFF_W   = baro_pkg::COEFF_W;
   localparam int CSR_IDX_W = baro_pkg::CSR_IDX_W;
   localparam int PRESS_W   = baro_pkg::PRESS_W;
   localparam int TEMP_W    = baro_pkg::TEMP_W;

   localparam int PRESS_DEPTH   = 8;
   localparam int TEMP_DEPTH    = 8;
   localparam int NUM_COEFFS    = 6;
   localparam int SETTLE_CYCLES = 64;
   localparam int QUIET_LIMIT   = 3000;
   localparam int PHASE_ITEMS   = 180;

   localparam logic CMD_PRESSURE    = 1'b0;
   localparam logic CMD_TEMPERATURE = 1'b1;

   // indexes past the last coefficient; writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam longint PRESS_MAX = 4194303;
   localparam longint PRESS_MIN = -4194304;
   localparam longint TEMP_MAX  = 262143;
   localparam longint TEMP_MIN  = -262144;

   typedef struct packed {
      logic signed [PRESS_W-1:0] pressure;
      logic signed [TEMP_W-1:0]  temperature;
      logic [SAMPLE_W-1:0]       avg_pressure;
      logic [SAMPLE_W-1:0]       avg_temperature;
   } baro_result_t;

   class baro_scoreboard;
      int           sens, offset, sens_temp, offset_temp, ref_temp, temp_slope;
      int unsigned  press_ring[PRESS_DEPTH];
      int unsigned  temp_ring[TEMP_DEPTH];
      int           press_slot, temp_slot;
      baro_result_t pending_results[$];
      int           errors;

      function new();
         sens = 0; offset = 0; sens_temp = 0; offset_temp = 0; ref_temp = 0; temp_slope = 0;
         foreach (press_ring[i]) press_ring[i] = 0;
         foreach (temp_ring[i]) temp_ring[i] = 0;
         press_slot = 0;
         temp_slot  = 0;
         errors     = 0;
      endfunction

      function void write_coeff(logic [CSR_IDX_W-1:0] idx, logic [COEFF_W-1:0] data);
         case (idx)
            baro_pkg::CSR_SENS:        sens        = data;
            baro_pkg::CSR_OFFSET:      offset      = data;
            baro_pkg::CSR_SENS_TEMP:   sens_temp   = data;
            baro_pkg::CSR_OFFSET_TEMP: offset_temp = data;
            baro_pkg::CSR_REF_TEMP:    ref_temp    = data;
            baro_pkg::CSR_TEMP_SLOPE:  temp_slope  = data;
            default: ;
         endcase
      endfunction

      function baro_result_t compensate();
         longint sum_p, sum_t, d1, d2, dt, temp, off, sens_full, p;
         baro_result_t r;
         sum_p = 0;
         sum_t = 0;
         foreach (press_ring[i]) sum_p += press_ring[i];
         foreach (temp_ring[i]) sum_t += temp_ring[i];
         // whole ring is averaged, reset zeros included
         d1 = sum_p / PRESS_DEPTH;
         d2 = sum_t / TEMP_DEPTH;
         dt   = d2 - longint'(ref_temp) * 256;
         temp = 2000 + ((dt * longint'(temp_slope)) >>> 23);
         off  = longint'(offset) * 65536 + ((longint'(offset_temp) * dt) >>> 7);
         sens_full = longint'(sens) * 32768 + ((longint'(sens_temp) * dt) >>> 8);
         p = (((d1 * sens_full) >>> 21) - off) >>> 15;
         if (p > PRESS_MAX) p = PRESS_MAX;
         if (p < PRESS_MIN) p = PRESS_MIN;
         if (temp > TEMP_MAX) temp = TEMP_MAX;
         if (temp < TEMP_MIN) temp = TEMP_MIN;
         r.pressure        = p[PRESS_W-1:0];
         r.temperature     = temp[TEMP_W-1:0];
         r.avg_pressure    = d1[SAMPLE_W-1:0];
         r.avg_temperature = d2[SAMPLE_W-1:0];
         return r;
      endfunction

      function void note_sample(logic cmd, logic [SAMPLE_W-1:0] smp);
         if (cmd == CMD_TEMPERATURE) begin
            temp_ring[temp_slot] = smp;
            temp_slot = (temp_slot + 1) % TEMP_DEPTH;
         end else begin
            press_ring[press_slot] = smp;
            press_slot = (press_slot + 1) % PRESS_DEPTH;
            pending_results.push_back(compensate());
         end
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      task report(string msg);
         errors++;
         $display("ERROR @%0t: %s", $realtime, msg);
      endtask

      task check_result(baro_result_t got);
         baro_result_t want;
         if (pending_results.size() == 0) begin
            report($sformatf("result with no pressure item outstanding (pressure %0d)",
                             got.pressure));
            return;
         end
         want = pending_results.pop_front();
         if (got.pressure !== want.pressure)
            report($sformatf("pressure: got %0d, expected %0d", got.pressure, want.pressure));
         if (got.temperature !== want.temperature)
            report($sformatf("temperature: got %0d, expected %0d",
                             got.temperature, want.temperature));
         if (got.avg_pressure !== want.avg_pressure)
            report($sformatf("avg_pressure_raw: got %h, expected %h",
                             got.avg_pressure, want.avg_pressure));
         if (got.avg_temperature !== want.avg_temperature)
            report($sformatf("avg_temperature_raw: got %h, expected %h",
                             got.avg_temperature, want.avg_temperature));
      endtask
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic                       req_cmd;
   logic [SAMPLE_W-1:0]        req_sample;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic signed [PRESS_W-1:0]  rsp_pressure;
   logic signed [TEMP_W-1:0]   rsp_temperature;
   logic [SAMPLE_W-1:0]        rsp_avg_pressure_raw;
   logic [SAMPLE_W-1:0]        rsp_avg_temperature_raw;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [COEFF_W-1:0]         csr_data;

   baro_scoreboard compensation_sb;
   baro_result_t   rsp_item;
   bit             req_idling;
   bit             rsp_stalls;
   int             ready_hold = 0;
   int             ready_roll;
   int             quiet_cycles = 0;

   baro_average_and_compensate_top #(
      .PRESSURE_SAMPLES    (PRESS_DEPTH),
      .TEMPERATURE_SAMPLES (TEMP_DEPTH)
   ) dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_cmd                 (req_cmd),
      .req_sample              (req_sample),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_pressure            (rsp_pressure),
      .rsp_temperature         (rsp_temperature),
      .rsp_avg_pressure_raw    (rsp_avg_pressure_raw),
      .rsp_avg_temperature_raw (rsp_avg_temperature_raw),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_index               (csr_index),
      .csr_data                (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // result side backpressure: mostly short stalls, now and then a long one
   always @(posedge clock) begin
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else if (!rsp_stalls) begin
         rsp_ready <= 1'b1;
      end else begin
         ready_roll = $urandom_range(0, 99);
         if (ready_roll < 55) begin
            rsp_ready  <= 1'b1;
            ready_hold <= $urandom_range(0, 6);
         end else if (ready_roll < 92) begin
            rsp_ready  <= 1'b0;
            ready_hold <= $urandom_range(0, 3);
         end else begin
            rsp_ready  <= 1'b0;
            ready_hold <= $urandom_range(10, 50);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_item.pressure        = rsp_pressure;
         rsp_item.temperature     = rsp_temperature;
         rsp_item.avg_pressure    = rsp_avg_pressure_raw;
         rsp_item.avg_temperature = rsp_avg_temperature_raw;
         compensation_sb.check_result(rsp_item);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic int pick_gap();
      int roll;
      if (!req_idling) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [SAMPLE_W-1:0] near_sample(int unsigned center);
      longint v;
      v = longint'(center) + longint'($urandom_range(0, 8191)) - 4096;
      if (v < 0) v = 0;
      if (v > 24'hFFFFFF) v = 24'hFFFFFF;
      return v[SAMPLE_W-1:0];
   endfunction

   function automatic logic [SAMPLE_W-1:0] corner_sample();
      case ($urandom_range(0, 3))
         0:       return 24'h000000;
         1:       return 24'hFFFFFF;
         2:       return 24'h800000;
         default: return 24'h7FFFFF;
      endcase
   endfunction

   // called at a clock edge; returns at the edge where the item is taken
   task automatic send_req(input logic cmd, input logic [SAMPLE_W-1:0] smp);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_cmd    <= cmd;
      req_sample <= smp;
      do @(posedge clock); while (!req_ready);
      compensation_sb.note_sample(cmd, smp);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [COEFF_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      compensation_sb.write_coeff(idx, data);
   endtask

   task automatic write_coeffs(input int unsigned words[NUM_COEFFS], input bit poke_spare);
      for (int i = 0; i < NUM_COEFFS; i++)
         csr_write(CSR_IDX_W'(baro_pkg::CSR_SENS + i), words[i][COEFF_W-1:0]);
      if (poke_spare) begin
         csr_write(CSR_SPARE_LO, COEFF_W'($urandom));
         csr_write(CSR_SPARE_HI, 16'hFFFF);
      end
      csr_valid <= 1'b0;
   endtask

   // temperature items give no result, so wait out a possible one in work
   task automatic drain();
      req_valid <= 1'b0;
      while (compensation_sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mostly temperature/pressure pairs around drifting levels, some noise
   task automatic run_random(input int n);
      int          sent;
      int          pick;
      int unsigned t_center, p_center;
      sent     = 0;
      t_center = $urandom_range(0, 24'hFFFFFF);
      p_center = $urandom_range(0, 24'hFFFFFF);
      while (sent < n) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            send_req(CMD_TEMPERATURE, near_sample(t_center));
            send_req(CMD_PRESSURE, near_sample(p_center));
            sent += 2;
            if ($urandom_range(0, 15) == 0) begin
               t_center = $urandom_range(0, 24'hFFFFFF);
               p_center = $urandom_range(0, 24'hFFFFFF);
            end
         end else if (pick < 9) begin
            send_req(1'($urandom_range(0, 1)), SAMPLE_W'($urandom));
            sent++;
         end else begin
            send_req(1'($urandom_range(0, 1)), corner_sample());
            sent++;
         end
      end
   endtask

   initial begin
      int unsigned typical[NUM_COEFFS] = '{40127, 36924, 23317, 23282, 33464, 28312};
      int unsigned words[NUM_COEFFS];

      compensation_sb = new();
      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_cmd    <= CMD_PRESSURE;
      req_sample <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= baro_pkg::CSR_SENS;
      csr_data   <= '0;
      req_idling = 1'b1;
      rsp_stalls = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // coefficients still at reset, rings mostly zero
      send_req(CMD_PRESSURE, 24'hFFFFFF);
      send_req(CMD_TEMPERATURE, 24'hFFFFFF);
      send_req(CMD_PRESSURE, 24'h000000);
      drain();

      // nine of each so both slots wrap
      write_coeffs(typical, 1'b1);
      for (int i = 0; i < 9; i++)
         send_req(CMD_TEMPERATURE, i[0] ? 24'hFFFFFF : 24'h000000);
      for (int i = 0; i < 9; i++)
         send_req(CMD_PRESSURE, i[0] ? 24'hFFFFFF : 24'h000000);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: words = typical;
            1: foreach (words[i]) words[i] = 16'hFFFF;
            2: foreach (words[i]) words[i] = 0;
            3: begin
               foreach (words[i]) words[i] = 16'hFFFF;
               words[baro_pkg::CSR_REF_TEMP] = 0;
            end
            default: foreach (words[i]) words[i] = $urandom_range(0, 16'hFFFF);
         endcase
         req_idling = (ph != 1);
         rsp_stalls = (ph != 2);
         write_coeffs(words, ph >= 4);
         run_random(PHASE_ITEMS);
         drain();
      end

      if (compensation_sb.pending() != 0)
         compensation_sb.report("pressure results never delivered");
      if (compensation_sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
